@@ sv/pee_pkg.sv @@
// ----------------------------------------------------------------------------
// pee_pkg
// shared sizes, token codes, control types and saturation helpers for the
// postfix evaluator
// ----------------------------------------------------------------------------
package pee_pkg;

  localparam int STACK_DEPTH   = 64;
  localparam int VALUE_WIDTH   = 48;
  localparam int FRACTION_BITS = 16;

  // scaled dividend / quotient width
  localparam int QUOT_WIDTH = VALUE_WIDTH + FRACTION_BITS;
  // partial product / remainder register width
  localparam int ACC_WIDTH  = VALUE_WIDTH + 1;
  // widest magnitude handed to the saturation step
  localparam int MAG_WIDTH  = ACC_WIDTH + QUOT_WIDTH;
  localparam int SP_WIDTH   = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_WIDTH = $clog2(STACK_DEPTH);
  localparam int CNT_WIDTH  = $clog2(QUOT_WIDTH);

  localparam logic [7:0] TOK_ADD    = 8'd43;
  localparam logic [7:0] TOK_SUB    = 8'd45;
  localparam logic [7:0] TOK_MUL    = 8'd42;
  localparam logic [7:0] TOK_DIV    = 8'd47;
  localparam logic [7:0] DIGIT_BASE = 8'd48;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  localparam value_t VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam value_t VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  localparam logic [MAG_WIDTH-1:0] NEG_LIM = MAG_WIDTH'(1) << (VALUE_WIDTH - 1);
  localparam logic [MAG_WIDTH-1:0] POS_LIM = NEG_LIM - MAG_WIDTH'(1);

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic    load;
    alu_op_t op;
  } alu_ctrl_t;

  typedef struct packed {
    logic done;
    logic divz;
  } alu_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_R,
    ST_POP_L,
    ST_LOAD,
    ST_WAIT,
    ST_PUSH,
    ST_RD_OUT,
    ST_EMIT
  } state_t;

  // sign and magnitude to a saturated value
  function automatic value_t sat_sm(input logic neg, input logic [MAG_WIDTH-1:0] mag);
    logic [MAG_WIDTH-1:0] twos;
    value_t               r;
    twos = ~mag + MAG_WIDTH'(1);
    if (neg) begin
      r = (mag > NEG_LIM) ? VALUE_MIN : $signed(twos[VALUE_WIDTH-1:0]);
    end else begin
      r = (mag > POS_LIM) ? VALUE_MAX : $signed(mag[VALUE_WIDTH-1:0]);
    end
    return r;
  endfunction

  // magnitude; the most negative value fits as unsigned
  function automatic logic [VALUE_WIDTH-1:0] abs_val(input value_t v);
    logic [VALUE_WIDTH-1:0] u;
    u = v;
    if (u[VALUE_WIDTH-1]) begin
      u = ~u + VALUE_WIDTH'(1);
    end
    return u;
  endfunction

  function automatic logic is_operator(input logic [7:0] tok);
    return (tok == TOK_ADD) || (tok == TOK_SUB) || (tok == TOK_MUL) || (tok == TOK_DIV);
  endfunction

  function automatic alu_op_t op_of(input logic [7:0] tok);
    alu_op_t op;
    case (tok)
      TOK_ADD: op = ALU_ADD;
      TOK_SUB: op = ALU_SUB;
      TOK_MUL: op = ALU_MUL;
      default: op = ALU_DIV;
    endcase
    return op;
  endfunction

  // non-operator byte: (byte - 48) scaled to fixed point
  function automatic value_t digit_value(input logic [7:0] tok);
    logic       neg;
    logic [7:0] m;
    neg = tok < DIGIT_BASE;
    m   = neg ? (DIGIT_BASE - tok) : (tok - DIGIT_BASE);
    return sat_sm(neg, MAG_WIDTH'(m) << FRACTION_BITS);
  endfunction

endpackage

@@ sv/pee_stack.sv @@
// ----------------------------------------------------------------------------
// pee_stack
// value stack storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module pee_stack (
  input  logic                           clk,
  input  logic                           we,
  input  logic [pee_pkg::ADDR_WIDTH-1:0] waddr,
  input  pee_pkg::value_t                wdata,
  input  logic                           re,
  input  logic [pee_pkg::ADDR_WIDTH-1:0] raddr,
  output pee_pkg::value_t                rdata
);
  import pee_pkg::*;

  value_t mem [STACK_DEPTH];
  value_t rdata_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign rdata = rdata_q;

endmodule

@@ sv/pee_alu.sv @@
// ----------------------------------------------------------------------------
// pee_alu
// shared add/subtract unit: one pass for add and subtract, shift-add
// multiply and restoring divide one bit per cycle, then saturation
// ----------------------------------------------------------------------------
module pee_alu (
  input  logic               clk,
  input  logic               rst,
  input  pee_pkg::alu_ctrl_t ctrl,
  input  pee_pkg::value_t    left,
  input  pee_pkg::value_t    right,
  output pee_pkg::alu_stat_t stat,
  output pee_pkg::value_t    result
);
  import pee_pkg::*;

  // control
  logic                 busy;
  logic                 fin;
  logic                 done;
  logic                 divz;
  logic [CNT_WIDTH-1:0] cnt;

  // working registers
  alu_op_t                op;
  logic                   neg;
  logic [ACC_WIDTH-1:0]   acc;
  logic [QUOT_WIDTH-1:0]  sh;
  logic [VALUE_WIDTH-1:0] opa;
  value_t                 res;

  logic [VALUE_WIDTH-1:0] abs_l;
  logic [VALUE_WIDTH-1:0] abs_r;
  logic [ACC_WIDTH-1:0]   rem_in;
  logic [ACC_WIDTH:0]     add_x;
  logic [ACC_WIDTH:0]     add_y;
  logic                   add_sub;
  logic [ACC_WIDTH:0]     sum;
  logic                   add_ovf;
  value_t                 add_res;
  logic [MAG_WIDTH-1:0]   prod;
  logic [MAG_WIDTH-1:0]   fin_mag;

  assign abs_l  = abs_val(left);
  assign abs_r  = abs_val(right);
  assign rem_in = {acc[VALUE_WIDTH-1:0], sh[QUOT_WIDTH-1]};

  // operand select for the one adder
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    if (busy) begin
      if (op == ALU_DIV) begin
        add_x   = {1'b0, rem_in};
        add_y   = {2'b00, opa};
        add_sub = 1'b1;
      end else begin
        add_x = {1'b0, acc};
        add_y = sh[0] ? {2'b00, opa} : '0;
      end
    end else begin
      add_x   = {{2{left[VALUE_WIDTH-1]}}, left};
      add_y   = {{2{right[VALUE_WIDTH-1]}}, right};
      add_sub = (ctrl.op == ALU_SUB);
    end
    sum = add_x + (add_sub ? ~add_y : add_y) + {{ACC_WIDTH{1'b0}}, add_sub};
  end

  // signed sum out of range when the top bits disagree
  assign add_ovf = ~(&sum[ACC_WIDTH:VALUE_WIDTH-1]) & (|sum[ACC_WIDTH:VALUE_WIDTH-1]);
  assign add_res = add_ovf ? (sum[ACC_WIDTH] ? VALUE_MIN : VALUE_MAX)
                           : $signed(sum[VALUE_WIDTH-1:0]);

  assign prod    = MAG_WIDTH'({acc, sh[QUOT_WIDTH-1:QUOT_WIDTH-VALUE_WIDTH]});
  assign fin_mag = (op == ALU_MUL) ? (prod >> FRACTION_BITS) : MAG_WIDTH'(sh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      divz <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      divz <= 1'b0;
      fin  <= 1'b0;
      if (ctrl.load) begin
        case (ctrl.op)
          ALU_ADD, ALU_SUB: begin
            done <= 1'b1;
          end
          ALU_MUL: begin
            busy <= 1'b1;
            cnt  <= CNT_WIDTH'(VALUE_WIDTH - 1);
          end
          ALU_DIV: begin
            if (abs_r == '0) begin
              done <= 1'b1;
              divz <= 1'b1;
            end else begin
              busy <= 1'b1;
              cnt  <= CNT_WIDTH'(QUOT_WIDTH - 1);
            end
          end
          default: begin
            done <= 1'b0;
          end
        endcase
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
        cnt <= cnt - CNT_WIDTH'(1);
      end else if (fin) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      op  <= ctrl.op;
      neg <= left[VALUE_WIDTH-1] ^ right[VALUE_WIDTH-1];
      acc <= '0;
      case (ctrl.op)
        ALU_ADD, ALU_SUB: begin
          res <= add_res;
        end
        ALU_MUL: begin
          opa <= abs_l;
          sh  <= QUOT_WIDTH'(abs_r);
        end
        ALU_DIV: begin
          opa <= abs_r;
          sh  <= QUOT_WIDTH'(abs_l) << FRACTION_BITS;
          // zero divisor: limit by the dividend's sign
          res <= left[VALUE_WIDTH-1] ? VALUE_MIN : VALUE_MAX;
        end
        default: begin
          res <= add_res;
        end
      endcase
    end else if (busy) begin
      if (op == ALU_DIV) begin
        acc <= ~sum[ACC_WIDTH] ? sum[ACC_WIDTH-1:0] : rem_in;
        sh  <= {sh[QUOT_WIDTH-2:0], ~sum[ACC_WIDTH]};
      end else begin
        acc <= sum[ACC_WIDTH:1];
        sh  <= {sum[0], sh[QUOT_WIDTH-1:1]};
      end
    end else if (fin) begin
      res <= sat_sm(neg, fin_mag);
    end
  end

  assign stat   = '{done: done, divz: divz};
  assign result = res;

endmodule

@@ sv/postfix_expression_evaluator_unit.sv @@
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_unit
// postfix token evaluator over a fixed-point value stack
// ----------------------------------------------------------------------------
// sequence: a digit is pushed straight from idle; an operator pops the right, then
//   the left operand, loads the shared unit, waits for its done and pushes; a last
//   token then reads the bottom entry and loads the result word, waiting in emit
//   while an earlier word is still held; a zero divisor skips the bit loop
// flow: one token at a time, taken only in idle; mul/div loop one bit per cycle
// reset: clears sequencer, stack pointer, flags and result valid, not the stack
module postfix_expression_evaluator_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            token_valid,
  output logic            token_ready,
  input  logic [7:0]      token,
  input  logic            last,
  output logic            result_valid,
  input  logic            result_ready,
  output pee_pkg::value_t value,
  output logic            underflow,
  output logic            overflow,
  output logic            divide_by_zero
);
  import pee_pkg::*;

  // sequencer and stack control
  state_t              state;
  state_t              state_next;
  logic [SP_WIDTH-1:0] sp;
  logic [SP_WIDTH-1:0] sp_dec;
  logic                under_flag;
  logic                over_flag;
  logic                divz_flag;
  logic                rd_pend;

  // current token word
  logic [7:0] tok_word;
  logic       is_last;
  logic       is_op;
  value_t     right_val;

  // stack port
  logic                  mem_we;
  logic [ADDR_WIDTH-1:0] mem_waddr;
  value_t                mem_wdata;
  logic                  mem_re;
  logic [ADDR_WIDTH-1:0] mem_raddr;
  value_t                mem_rdata;

  // shared unit
  alu_ctrl_t alu_ctrl;
  alu_stat_t alu_stat;
  value_t    alu_left;
  value_t    alu_result;

  logic pop_ok;
  logic push_ok;
  logic take;
  logic emit_go;

  assign sp_dec  = sp - SP_WIDTH'(1);
  assign pop_ok  = (sp != '0);
  assign push_ok = (sp != SP_WIDTH'(STACK_DEPTH));
  assign take    = token_valid && token_ready;

  pee_stack u_stack (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  pee_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (alu_ctrl),
    .left   (alu_left),
    .right  (right_val),
    .stat   (alu_stat),
    .result (alu_result)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (token_valid) begin
          state_next = is_operator(token) ? ST_POP_R : ST_PUSH;
        end
      end
      ST_POP_R:  state_next = ST_POP_L;
      ST_POP_L:  state_next = ST_LOAD;
      ST_LOAD:   state_next = ST_WAIT;
      ST_WAIT: begin
        if (alu_stat.done) begin
          state_next = ST_PUSH;
        end
      end
      ST_PUSH:   state_next = is_last ? ST_RD_OUT : ST_IDLE;
      ST_RD_OUT: state_next = ST_EMIT;
      ST_EMIT: begin
        if (!result_valid || result_ready) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    token_ready = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = sp_dec[ADDR_WIDTH-1:0];
    mem_we      = 1'b0;
    mem_waddr   = sp[ADDR_WIDTH-1:0];
    mem_wdata   = is_op ? alu_result : digit_value(tok_word);
    alu_ctrl    = '{load: 1'b0, op: op_of(tok_word)};
    emit_go     = 1'b0;
    case (state)
      ST_IDLE: begin
        token_ready = 1'b1;
      end
      // right operand first, then left, each from the top of stack
      ST_POP_R, ST_POP_L: begin
        mem_re = pop_ok;
      end
      ST_LOAD: begin
        alu_ctrl.load = 1'b1;
      end
      ST_PUSH: begin
        // a full stack drops the word
        mem_we = push_ok;
      end
      ST_RD_OUT: begin
        // bottom entry for the result word
        mem_re    = 1'b1;
        mem_raddr = '0;
      end
      ST_EMIT: begin
        emit_go = !result_valid || result_ready;
      end
      default: begin
        token_ready = 1'b0;
      end
    endcase
  end

  // left operand comes straight from the read register; empty pop gives 0
  assign alu_left = rd_pend ? mem_rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      sp           <= '0;
      under_flag   <= 1'b0;
      over_flag    <= 1'b0;
      divz_flag    <= 1'b0;
      rd_pend      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_POP_R || state == ST_POP_L) begin
        rd_pend <= pop_ok;
        if (pop_ok) begin
          sp <= sp_dec;
        end else begin
          under_flag <= 1'b1;
        end
      end
      if (state == ST_WAIT && alu_stat.done && alu_stat.divz) begin
        divz_flag <= 1'b1;
      end
      if (state == ST_PUSH) begin
        if (push_ok) begin
          sp <= sp + SP_WIDTH'(1);
        end else begin
          over_flag <= 1'b1;
        end
      end
      // result word goes out, expression state starts over
      if (emit_go) begin
        sp         <= '0;
        under_flag <= 1'b0;
        over_flag  <= 1'b0;
        divz_flag  <= 1'b0;
      end
      if (emit_go) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (take) begin
      tok_word <= token;
      is_last  <= last;
      is_op    <= is_operator(token);
    end
    if (state == ST_POP_L) begin
      right_val <= rd_pend ? mem_rdata : '0;
    end
    if (emit_go) begin
      value          <= pop_ok ? mem_rdata : '0;
      underflow      <= under_flag;
      overflow       <= over_flag;
      divide_by_zero <= divz_flag;
    end
  end

  // stack pointer never runs past the storage depth
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SP_WIDTH'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  // shared unit only finishes while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    alu_stat.done |-> state == ST_WAIT)
    else $error("arithmetic unit finished outside wait state");

  // emitting a word leaves an empty stack with clear flags
  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    emit_go |=> (sp == '0 && !under_flag && !over_flag && !divz_flag && result_valid))
    else $error("expression state not cleared after result word");

endmodule

@@ sim/postfix_expression_evaluator_unit_test.sv @@
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_unit_test
// self-checking bench for the postfix evaluator: token words go in over a
// valid/ready channel, a scoreboard keeps its own value stack and fault flags,
// and every result word is compared field by field with the oldest
// expression it has evaluated
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  import pee_pkg::*;

  // cycles with no word moving on either channel before the run is abandoned
  localparam int STALL_LIMIT  = 3000;
  // long receiver hold-off so the block fills up and stalls its input
  localparam int HOLD_CYCLES  = 400;
  // drain margin for a divide, the slowest token, plus the bottom-entry read
  localparam int DRAIN_CYCLES = 100;

  localparam logic L = 1'b1;
  localparam logic N = 1'b0;

  // one evaluated expression: what the result word must carry
  typedef struct packed {
    value_t res_value;
    logic   res_under;
    logic   res_over;
    logic   res_divz;
  } expr_result_t;

  // --------------------------------------------------------------------------
  // scoreboard: private copy of the value stack and fault flags
  // --------------------------------------------------------------------------
  class rpn_scoreboard;
    value_t       stack_mem [STACK_DEPTH];
    int unsigned  depth;
    logic         under_f;
    logic         over_f;
    logic         divz_f;
    expr_result_t evaluated_exprs [$];
    int           errors;

    function new();
      depth   = 0;
      under_f = 1'b0;
      over_f  = 1'b0;
      divz_f  = 1'b0;
      errors  = 0;
    endfunction

    function logic [127:0] magnitude(value_t v);
      logic signed [127:0] w;
      w = v;
      if (w < 0) w = -w;
      return w;
    endfunction

    // sign and magnitude clamped into the value range
    function value_t saturate(logic neg, logic [127:0] mag);
      logic [127:0] lim;
      logic [127:0] twos;
      lim = 128'(1) << (VALUE_WIDTH - 1);
      if (neg) begin
        if (mag > lim) mag = lim;
        twos = ~mag + 128'(1);
        return $signed(twos[VALUE_WIDTH-1:0]);
      end
      if (mag > lim - 128'(1)) mag = lim - 128'(1);
      return $signed(mag[VALUE_WIDTH-1:0]);
    endfunction

    function value_t saturate_sum(logic signed [127:0] s);
      logic [127:0] m;
      m = (s < 0) ? -s : s;
      return saturate(s < 0, m);
    endfunction

    function value_t apply_operator(logic [7:0] op_tok, value_t lhs, value_t rhs);
      logic signed [127:0] wide;
      logic [127:0]        prod;
      logic                neg;
      value_t              r;
      neg = lhs[VALUE_WIDTH-1] ^ rhs[VALUE_WIDTH-1];
      case (op_tok)
        TOK_ADD: begin
          wide = lhs;
          wide = wide + rhs;
          r = saturate_sum(wide);
        end
        TOK_SUB: begin
          wide = lhs;
          wide = wide - rhs;
          r = saturate_sum(wide);
        end
        TOK_MUL: begin
          prod = (magnitude(lhs) * magnitude(rhs)) >> FRACTION_BITS;
          r = saturate(neg, prod);
        end
        default: begin
          if (rhs == '0) begin
            // zero divisor saturates by the dividend's sign
            divz_f = 1'b1;
            r = lhs[VALUE_WIDTH-1] ? VALUE_MIN : VALUE_MAX;
          end else begin
            prod = (magnitude(lhs) << FRACTION_BITS) / magnitude(rhs);
            r = saturate(neg, prod);
          end
        end
      endcase
      return r;
    endfunction

    function void push_value(value_t v);
      if (depth >= STACK_DEPTH) begin
        over_f = 1'b1;
      end else begin
        stack_mem[depth] = v;
        depth++;
      end
    endfunction

    function value_t pop_value();
      if (depth == 0) begin
        under_f = 1'b1;
        return '0;
      end
      depth--;
      return stack_mem[depth];
    endfunction

    // accepted token word
    function void note_word(logic [7:0] tok, logic lst);
      value_t       rhs;
      value_t       lhs;
      logic         neg;
      logic [7:0]   m;
      expr_result_t res;
      if (tok == TOK_ADD || tok == TOK_SUB || tok == TOK_MUL || tok == TOK_DIV) begin
        rhs = pop_value();
        lhs = pop_value();
        push_value(apply_operator(tok, lhs, rhs));
      end else begin
        neg = tok < DIGIT_BASE;
        m   = neg ? (DIGIT_BASE - tok) : (tok - DIGIT_BASE);
        push_value(saturate(neg, 128'(m) << FRACTION_BITS));
      end
      if (lst) begin
        res.res_value = (depth > 0) ? stack_mem[0] : '0;
        res.res_under = under_f;
        res.res_over  = over_f;
        res.res_divz  = divz_f;
        evaluated_exprs.push_back(res);
        depth   = 0;
        under_f = 1'b0;
        over_f  = 1'b0;
        divz_f  = 1'b0;
      end
    endfunction

    // accepted result word
    function void check_result(value_t v, logic uf, logic of, logic dz);
      expr_result_t want;
      if (evaluated_exprs.size() == 0) begin
        $display("%0t: result word with no expression pending, value %0d", $time,
                 $signed(v));
        errors++;
        return;
      end
      want = evaluated_exprs.pop_front();
      if (want.res_value !== v) begin
        $display("%0t: value expected %0d actual %0d", $time, $signed(want.res_value),
                 $signed(v));
        errors++;
      end
      if (want.res_under !== uf) begin
        $display("%0t: underflow expected %0b actual %0b", $time, want.res_under, uf);
        errors++;
      end
      if (want.res_over !== of) begin
        $display("%0t: overflow expected %0b actual %0b", $time, want.res_over, of);
        errors++;
      end
      if (want.res_divz !== dz) begin
        $display("%0t: divide_by_zero expected %0b actual %0b", $time, want.res_divz, dz);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return evaluated_exprs.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // signals and block under test
  // --------------------------------------------------------------------------
  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       token_valid  = 1'b0;
  logic       token_ready;
  logic [7:0] token        = 8'd0;
  logic       last         = 1'b0;
  logic       result_valid;
  logic       result_ready = 1'b0;
  value_t     value;
  logic       underflow;
  logic       overflow;
  logic       divide_by_zero;

  rpn_scoreboard sb;

  // idle odds in percent, changed per phase
  int tx_idle_pct  = 19;
  int rx_idle_pct  = 75;
  // set once by the stimulus, picked up and counted by the receiver
  bit hold_request = 1'b0;
  int hold_left    = 0;
  int words_sent   = 0;
  int stall_cycles = 0;

  postfix_expression_evaluator_unit dut (
    .clk            (clk),
    .rst            (rst),
    .token_valid    (token_valid),
    .token_ready    (token_ready),
    .token          (token),
    .last           (last),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .value          (value),
    .underflow      (underflow),
    .overflow       (overflow),
    .divide_by_zero (divide_by_zero)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // receiver: checks accepted result words, then picks ready for the next
  // cycle; a pending hold request turns into a long run of ready low
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      sb.check_result(value, underflow, overflow, divide_by_zero);
    end
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too long with no word moving on either side ends the run
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (token_valid && token_ready) || (result_valid && result_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // sender: optional idle gap, then offer the word until it is taken;
  // valid is left high after acceptance so back-to-back words never drop it
  // --------------------------------------------------------------------------
  task automatic send_word(input logic [7:0] tok, input logic lst);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      token_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    token_valid <= 1'b1;
    token       <= tok;
    last        <= lst;
    @(posedge clk);
    while (!token_ready) @(posedge clk);
    sb.note_word(tok, lst);
    words_sent++;
  endtask

  // non-operator byte, biased toward digits and the push extremes
  function automatic logic [7:0] pick_operand();
    int         r;
    logic [7:0] b;
    r = $urandom_range(99);
    if (r < 45) begin
      b = DIGIT_BASE + 8'($urandom_range(9));
    end else if (r < 60) begin
      case ($urandom_range(3))
        0: b = 8'd0;
        1: b = 8'd255;
        2: b = DIGIT_BASE;
        default: b = DIGIT_BASE + 8'd9;
      endcase
    end else begin
      b = 8'($urandom_range(255));
      while (b == TOK_ADD || b == TOK_SUB || b == TOK_MUL || b == TOK_DIV) begin
        b = 8'($urandom_range(255));
      end
    end
    return b;
  endfunction

  function automatic logic [7:0] pick_operator();
    logic [7:0] b;
    case ($urandom_range(3))
      0: b = TOK_ADD;
      1: b = TOK_SUB;
      2: b = TOK_MUL;
      default: b = TOK_DIV;
    endcase
    return b;
  endfunction

  // one random expression, last set on its final word
  task automatic send_expression();
    int         kind;
    int         n_operands;
    int         placed;
    int         depth;
    int         len;
    int         n_ops;
    int         i;
    logic       done;
    logic [7:0] tok;
    kind = $urandom_range(99);
    if (kind < 75) begin
      // well-formed postfix with random operands and operators
      n_operands = $urandom_range(1, 7);
      placed     = 0;
      depth      = 0;
      done       = 1'b0;
      while (!done) begin
        if (placed < n_operands && (depth < 2 || $urandom_range(1) == 1)) begin
          tok = pick_operand();
          placed++;
          depth++;
        end else begin
          tok = pick_operator();
          depth--;
        end
        done = !(placed < n_operands || depth > 1);
        send_word(tok, done);
      end
    end else if (kind < 77) begin
      // deep run of pushes, may run past the stack top
      len   = $urandom_range(60, 70);
      n_ops = $urandom_range(0, 3);
      for (i = 0; i < len + n_ops; i++) begin
        tok = (i < len) ? pick_operand() : pick_operator();
        send_word(tok, i == len + n_ops - 1);
      end
    end else begin
      // broken sequence: operators and raw bytes in any order
      len = $urandom_range(1, 8);
      for (i = 0; i < len; i++) begin
        tok = ($urandom_range(1) == 1) ? pick_operator() : 8'($urandom_range(255));
        send_word(tok, i == len - 1);
      end
    end
  endtask

  // short directed script: push extremes, each operator, empty pop,
  // zero divisor on negative and zero dividends, large multiply and divide
  task automatic run_directed();
    logic [8:0] script [30];
    int         i;
    script = '{
      {L, 8'd0},                                   // lowest push
      {L, 8'd255},                                 // highest push
      {L, TOK_ADD},                                // pops from empty stack
      {N, "3"}, {N, "4"}, {L, TOK_ADD},
      {N, "9"}, {N, "5"}, {L, TOK_SUB},
      {N, "7"}, {N, 8'd0}, {L, TOK_MUL},
      {N, "9"}, {N, "2"}, {L, TOK_DIV},            // fractional quotient
      {N, 8'd0}, {N, "0"}, {L, TOK_DIV},           // negative over zero
      {N, "0"}, {N, "0"}, {L, TOK_DIV},            // zero over zero
      {N, 8'd255}, {N, 8'd255}, {N, TOK_MUL},      // repeated product of the largest push
      {N, 8'd255}, {N, TOK_MUL},
      {N, "1"}, {N, 8'd255}, {N, TOK_DIV},         // tiny divisor
      {L, TOK_DIV}                                 // large product over the tiny divisor
    };
    for (i = 0; i < 30; i++) begin
      send_word(script[i][7:0], script[i][8]);
    end
  endtask

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // phase one: sender mostly busy, receiver mostly stalled
    run_directed();
    while (words_sent < 150) send_expression();

    // phase two: the other way round
    tx_idle_pct = 75;
    rx_idle_pct = 19;
    while (words_sent < 300) send_expression();

    // phase three: no idling, but one long receiver hold-off up front
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    hold_request = 1'b1;
    while (words_sent < 450) send_expression();
    token_valid <= 1'b0;

    // drain; the watchdog covers a result that never comes
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/pee_pkg.sv
sv/pee_stack.sv
sv/pee_alu.sv
sv/postfix_expression_evaluator_unit.sv
sim/postfix_expression_evaluator_unit_test.sv
